// ===== hdl/keyed_tile_span_window_emitter_top_defines.svh =====
// Assertion macros shared by the span window emitter modules.
`ifndef KEYED_TILE_SPAN_WINDOW_EMITTER_TOP_DEFINES_SVH
`define KEYED_TILE_SPAN_WINDOW_EMITTER_TOP_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define KTSWE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define KTSWE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ktswe_pkg.sv =====
// Shared types and constants of the span window emitter.
package ktswe_pkg;

    // Width of the chunk length field; covers chunks of up to 256 pixels.
    localparam int LEN_W = 9;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_KEY_COLOR     = 2'd0,
        CFG_SCREEN_WIDTH  = 2'd1,
        CFG_SCREEN_HEIGHT = 2'd2
    } t_ktswe_cfg_idx;

    // One closed, on-screen chunk waiting to be drained.
    typedef struct packed {
        logic [15:0]      left;
        logic [15:0]      row;
        logic [LEN_W-1:0] len;
        logic             bank;
    } t_ktswe_desc;

    // Drain side hands a span bank back to the front.
    typedef struct packed {
        logic valid;
        logic bank;
    } t_ktswe_rel;

    // Drain sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SETUP,
        BK_RUN
    } t_ktswe_bstate;

endpackage

// ===== hdl/ktswe_in_if.sv =====
// Pixel input channel.
interface ktswe_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel;
    logic [15:0] tile_x;
    logic [15:0] tile_y;
    logic [15:0] tile_width;
    logic        start_of_tile;

    modport source (
        output valid, pixel, tile_x, tile_y, tile_width, start_of_tile,
        input  ready
    );
    modport sink (
        input  valid, pixel, tile_x, tile_y, tile_width, start_of_tile,
        output ready
    );
endinterface

// ===== hdl/ktswe_out_if.sv =====
// Window pixel output channel.
interface ktswe_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] window_left;
    logic [15:0] window_row;
    logic [15:0] window_right;
    logic [15:0] out_pixel;
    logic        last_of_chunk;

    modport source (
        output valid, window_left, window_row, window_right, out_pixel, last_of_chunk,
        input  ready
    );
    modport sink (
        input  valid, window_left, window_row, window_right, out_pixel, last_of_chunk,
        output ready
    );
endinterface

// ===== hdl/ktswe_span_mem.sv =====
// Two-bank span pixel store, one write and one registered read port.
module ktswe_span_mem #(
    parameter int ADDR_W = 7
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [15:0]       i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [15:0]       o_rdata
);
    logic [15:0] r_mem [2**ADDR_W];
    logic [15:0] r_rdata;

    // Store pixels of the open chunk
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Fetch the next pixel for the drain
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/ktswe_queue.sv =====
// Two-entry queue of chunk descriptors between front and drain.
module ktswe_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  ktswe_pkg::t_ktswe_desc i_data,
    input  logic                  i_pop,
    output logic                  o_valid,
    output logic                  o_full,
    output ktswe_pkg::t_ktswe_desc o_data
);
    import ktswe_pkg::*;

    t_ktswe_desc r_data [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;

    // Hold entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wp] <= i_data;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_data[r_rp];
endmodule

// ===== hdl/ktswe_front.sv =====
// Front end: tracks tile position, gathers visible spans and closes chunks.
module ktswe_front #(
    parameter int CHUNK_MAX = 64,
    parameter int IDX_W     = 6,
    parameter int CNT_W     = 7
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    ktswe_in_if.sink               i_in,
    input  logic [15:0]            i_key_color,
    input  logic [15:0]            i_screen_width,
    input  logic [15:0]            i_screen_height,
    output logic                   o_mem_we,
    output logic [IDX_W:0]         o_mem_waddr,
    output logic [15:0]            o_mem_wdata,
    output logic                   o_push,
    output ktswe_pkg::t_ktswe_desc o_desc,
    input  logic                   i_q_full,
    input  ktswe_pkg::t_ktswe_rel  i_rel
);
    import ktswe_pkg::*;
    `include "keyed_tile_span_window_emitter_top_defines.svh"

    logic [CNT_W-1:0] r_cnt;
    logic [15:0]      r_start;
    logic [15:0]      r_col;
    logic [15:0]      r_row;
    logic             r_wbank;
    logic [1:0]       r_busy;

    logic [CNT_W-1:0] cnt_eff;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] len;
    logic [15:0]      col_eff;
    logic [15:0]      row_eff;
    logic [15:0]      start_eff;
    logic [15:0]      left;
    logic [15:0]      row_abs;
    logic             is_key;
    logic             eor;
    logic             close;
    logic             drop;
    logic             acc;
    logic             push;

    // Classify the incoming pixel against the open span
    always_comb begin
        col_eff   = i_in.start_of_tile ? 16'd0 : r_col;
        row_eff   = i_in.start_of_tile ? 16'd0 : r_row;
        cnt_eff   = i_in.start_of_tile ? '0 : r_cnt;
        start_eff = (cnt_eff == '0) ? col_eff : r_start;
        is_key    = (i_in.pixel == i_key_color);
        cnt_inc   = cnt_eff + CNT_W'(1);
        eor       = ({1'b0, col_eff} + 17'd1) >= {1'b0, i_in.tile_width};
        close     = is_key ? (cnt_eff != '0)
                           : ((cnt_inc == CNT_W'(CHUNK_MAX)) || eor);
        len       = is_key ? cnt_eff : cnt_inc;
        left      = i_in.tile_x + start_eff;
        row_abs   = i_in.tile_y + row_eff;
        drop      = (left >= i_screen_width) || (row_abs >= i_screen_height);
    end

    // Stall while the span bank is still being drained or the descriptor queue is full
    assign i_in.ready = !r_busy[r_wbank] && !i_q_full;
    assign acc        = i_in.valid && i_in.ready;
    assign push       = acc && close && !drop;

    assign o_mem_we    = acc && !is_key;
    assign o_mem_waddr = {r_wbank, cnt_eff[IDX_W-1:0]};
    assign o_mem_wdata = i_in.pixel;

    assign o_push      = push;
    assign o_desc.left = left;
    assign o_desc.row  = row_abs;
    assign o_desc.len  = LEN_W'(len);
    assign o_desc.bank = r_wbank;

    // Advance tile position and span state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_start <= 16'd0;
            r_col   <= 16'd0;
            r_row   <= 16'd0;
        end else if (acc) begin
            r_cnt   <= close ? '0 : len;
            r_start <= start_eff;
            r_col   <= eor ? 16'd0 : col_eff + 16'd1;
            r_row   <= eor ? row_eff + 16'd1 : row_eff;
        end
    end

    // Swap banks on each queued chunk, free them as the drain finishes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wbank <= 1'b0;
            r_busy  <= 2'b00;
        end else begin
            if (push) begin
                r_wbank         <= ~r_wbank;
                r_busy[r_wbank] <= 1'b1;
            end
            if (i_rel.valid) begin
                r_busy[i_rel.bank] <= 1'b0;
            end
        end
    end

    `KTSWE_ASSERT_NOW(a_push_free_bank, push, !r_busy[r_wbank], "chunk queued on a busy bank")
    `KTSWE_ASSERT_NOW(a_push_room, push, !i_q_full, "chunk queued into a full queue")
    `KTSWE_ASSERT_NEXT(a_push_swaps, push, r_wbank != $past(r_wbank), "bank not swapped")
endmodule

// ===== hdl/ktswe_back.sv =====
// Drain: clamps each chunk's window and streams its pixels out.
module ktswe_back #(
    parameter int IDX_W = 6
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [15:0]            i_screen_width,
    input  logic                   i_q_valid,
    input  ktswe_pkg::t_ktswe_desc i_q_data,
    output logic                   o_q_pop,
    output logic                   o_mem_re,
    output logic [IDX_W:0]         o_mem_raddr,
    input  logic [15:0]            i_mem_rdata,
    output ktswe_pkg::t_ktswe_rel  o_rel,
    ktswe_out_if.source            o_out
);
    import ktswe_pkg::*;
    `include "keyed_tile_span_window_emitter_top_defines.svh"

    t_ktswe_bstate    r_state;
    t_ktswe_bstate    n_state;
    logic [15:0]      r_left;
    logic [15:0]      r_row;
    logic [LEN_W-1:0] r_len;
    logic             r_bank;
    logic [15:0]      r_right;
    logic [15:0]      r_col;
    logic [IDX_W-1:0] r_idx;
    logic             r_ov;
    logic [15:0]      r_o_left;
    logic [15:0]      r_o_row;
    logic [15:0]      r_o_right;
    logic             r_o_last;

    logic             adv;
    logic             issue;
    logic             last;
    logic [16:0]      sum;
    logic [16:0]      lim;
    logic [15:0]      right;

    assign adv  = !r_ov || o_out.ready;
    assign last = (r_col == r_right);

    // Clamp the chunk's right edge to the screen
    always_comb begin
        sum   = {1'b0, r_left} + 17'(r_len) - 17'd1;
        lim   = {1'b0, i_screen_width} - 17'd1;
        right = (sum > lim) ? lim[15:0] : sum[15:0];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE:  if (i_q_valid) begin
                n_state = BK_SETUP;
            end
            BK_SETUP: n_state = BK_RUN;
            BK_RUN:   if (adv && last) begin
                n_state = BK_IDLE;
            end
            default:  n_state = BK_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_q_pop = 1'b0;
        issue   = 1'b0;
        unique case (r_state)
            BK_IDLE:  o_q_pop = i_q_valid;
            BK_SETUP: issue   = 1'b0;
            BK_RUN:   issue   = adv;
            default:  issue   = 1'b0;
        endcase
    end

    assign o_mem_re    = issue;
    assign o_mem_raddr = {r_bank, r_idx};
    assign o_rel.valid = issue && last;
    assign o_rel.bank  = r_bank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Load the chunk, then walk its pixels
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_left <= i_q_data.left;
            r_row  <= i_q_data.row;
            r_len  <= i_q_data.len;
            r_bank <= i_q_data.bank;
        end
        if (r_state == BK_SETUP) begin
            r_right <= right;
            r_col   <= r_left;
            r_idx   <= '0;
        end else if (issue) begin
            r_col <= r_col + 16'd1;
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    // Output register, refilled when empty or taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_o_left  <= r_left;
            r_o_row   <= r_row;
            r_o_right <= r_right;
            r_o_last  <= last;
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.window_left   = r_o_left;
    assign o_out.window_row    = r_o_row;
    assign o_out.window_right  = r_o_right;
    assign o_out.out_pixel     = i_mem_rdata;
    assign o_out.last_of_chunk = r_o_last;

    `KTSWE_ASSERT_NEXT(a_setup_runs, r_state == BK_SETUP, r_state == BK_RUN, "setup not followed by run")
    `KTSWE_ASSERT_NOW(a_col_in_window, r_state == BK_RUN, r_col <= r_right, "drain ran past window")
    `KTSWE_ASSERT_NEXT(a_last_shown, o_rel.valid, r_ov && r_o_last, "final pixel not presented")
endmodule

// ===== hdl/keyed_tile_span_window_emitter_top.sv =====
// Each pixel is taken while the span bank it lands in is free; a front end gathers
// visible runs into one of two span banks and queues every closed, on-screen chunk,
// while the drain sends one pixel per cycle unless its output stalls. For each chunk
// the drain first pops the descriptor and then clamps the right edge; input stalls
// only when both banks still await draining. Key pixels and dropped chunks leave
// nothing. Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data and must
// only change while the block is idle. No clearing pass follows reset.
module keyed_tile_span_window_emitter_top #(
    parameter int CHUNK_MAX = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ktswe_in_if.sink    i_in,
    ktswe_out_if.source o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import ktswe_pkg::*;

    localparam int IDX_W = (CHUNK_MAX > 1) ? $clog2(CHUNK_MAX) : 1;
    localparam int CNT_W = $clog2(CHUNK_MAX + 1);

    logic [15:0]    r_key_color;
    logic [15:0]    r_screen_width;
    logic [15:0]    r_screen_height;

    logic           mem_we;
    logic [IDX_W:0] mem_waddr;
    logic [15:0]    mem_wdata;
    logic           mem_re;
    logic [IDX_W:0] mem_raddr;
    logic [15:0]    mem_rdata;
    logic           push;
    logic           pop;
    logic           q_valid;
    logic           q_full;
    t_ktswe_desc    push_desc;
    t_ktswe_desc    q_desc;
    t_ktswe_rel     rel;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_color     <= 16'd0;
            r_screen_width  <= 16'd320;
            r_screen_height <= 16'd240;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY_COLOR:     r_key_color     <= i_cfg_data;
                CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data;
                default:           r_key_color     <= r_key_color;
            endcase
        end
    end

    ktswe_front #(
        .CHUNK_MAX (CHUNK_MAX),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in            (i_in),
        .i_key_color     (r_key_color),
        .i_screen_width  (r_screen_width),
        .i_screen_height (r_screen_height),
        .o_mem_we        (mem_we),
        .o_mem_waddr     (mem_waddr),
        .o_mem_wdata     (mem_wdata),
        .o_push          (push),
        .o_desc          (push_desc),
        .i_q_full        (q_full),
        .i_rel           (rel)
    );

    ktswe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_desc),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_desc)
    );

    ktswe_span_mem #(
        .ADDR_W (IDX_W + 1)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    ktswe_back #(
        .IDX_W (IDX_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_screen_width (r_screen_width),
        .i_q_valid      (q_valid),
        .i_q_data       (q_desc),
        .o_q_pop        (pop),
        .o_mem_re       (mem_re),
        .o_mem_raddr    (mem_raddr),
        .i_mem_rdata    (mem_rdata),
        .o_rel          (rel),
        .o_out          (o_out)
    );
endmodule
